>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL module of the MNA stamper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// A condition that implies another one in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// A condition that implies another one in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/mna_pkg.sv
// Package with codes, widths and saturating arithmetic of the MNA stamper.
`timescale 1ns / 1ps
`default_nettype none
package mna_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ADD_W       = VALUE_WIDTH + 1;
  localparam int DIV_W       = 2 * FRAC_BITS + 1;
  localparam int MAX_DIM_DEF = 128;

  localparam logic [1:0] CMD_STAMP  = 2'd0;
  localparam logic [1:0] CMD_RD_MAT = 2'd1;
  localparam logic [1:0] CMD_RD_VEC = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_RES = 2'd0;
  localparam logic [1:0] KIND_CUR = 2'd1;
  localparam logic [1:0] KIND_VS  = 2'd2;
  localparam logic [1:0] KIND_IND = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_RES  = 2'd2;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

  localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic signed [ADD_W-1:0] ADD_ONE = ADD_W'(1 << FRAC_BITS);
  localparam logic signed [ADD_W-1:0] ADD_MINUS_ONE = -ADD_ONE;

  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
    logic vec;
  } mem_ctl_t;

  // Adds a wide addend to a stored value and clamps to the value range.
  function automatic logic [VALUE_WIDTH-1:0] sat_add(
    input logic [VALUE_WIDTH-1:0] a,
    input logic [ADD_W-1:0]       b
  );
    logic [VALUE_WIDTH+1:0] s;
    s = {{2{a[VALUE_WIDTH-1]}}, a} + {b[ADD_W-1], b};
    if (s[VALUE_WIDTH+1:VALUE_WIDTH-1] == 3'b000 ||
        s[VALUE_WIDTH+1:VALUE_WIDTH-1] == 3'b111) begin
      return s[VALUE_WIDTH-1:0];
    end else if (s[VALUE_WIDTH+1]) begin
      return VMIN;
    end else begin
      return VMAX;
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mna_matrix_stamper.sv
// Top level of the MNA stamper: command sequencer around the stores and the reciprocal unit.
//
// Usage: the item channel (item_valid / item_stall) carries one command per
// transaction: stamp an element, read a matrix entry, read a vector entry, or
// clear the store. Every command returns exactly one transaction on the result
// channel (result_valid / result_stall) with read_value and status.
// node_count is written through the cfg channel (cfg_valid / cfg_ready);
// cfg_ready is always high, and a write only affects later commands.
// A command rejected with an error status goes straight to the result; reads
// pass through ST_RD and ST_RD_CAP. Resistors first wait on the bit-serial
// reciprocal unit; all stamps then go through the single memory port, where
// each update is a read-modify-write (ST_OP_RD, then ST_OP_WR) and each skipped
// update takes only an ST_OP_RD step. One command is in flight at a time; the
// next is taken once the previous result is registered.
// Reset and the clear command both sweep the memories, one matrix entry per
// cycle, over MAX_DIM * MAX_DIM entries (rounded up to a power of two per side);
// item_stall stays high during the sweep. A stalled result holds in the output
// register while the block may already accept and work on the next command.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mna_matrix_stamper import mna_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [1:0]             command,
  input  logic [1:0]             element_kind,
  input  logic [7:0]             node_plus,
  input  logic [7:0]             node_minus,
  input  logic [VALUE_WIDTH-1:0] element_value,
  input  logic [6:0]             read_row,
  input  logic [6:0]             read_column,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [VALUE_WIDTH-1:0] read_value,
  output logic [1:0]             status
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int XW = IW + 8;
  localparam int SW = 2 * IW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_OP_RD, ST_OP_WR, ST_RD, ST_RD_CAP, ST_DONE
  } state_t;

  state_t                 state;
  logic [7:0]             node_count;
  logic [IW:0]            extra_used;
  logic [SW-1:0]          sweep;
  logic                   clear_post;
  logic [2:0]             step;
  logic [1:0]             kind;
  logic [IW-1:0]          p;
  logic [IW-1:0]          m;
  logic [IW-1:0]          r;
  logic                   np_nz;
  logic                   nm_nz;
  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] g;
  logic [IW-1:0]          rd_row;
  logic [IW-1:0]          rd_col;
  logic                   rd_vec;
  logic [VALUE_WIDTH-1:0] pend_value;
  logic [1:0]             pend_status;
  logic                   div_start;

  logic                   accept;
  logic                   ok_p;
  logic                   ok_m;
  logic [XW-1:0]          np_x;
  logic [XW-1:0]          nm_x;
  logic [XW-1:0]          r_full;
  logic [XW-1:0]          row_x;
  logic [XW-1:0]          col_x;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_q;

  logic                   op_en;
  logic                   op_vec;
  logic [IW-1:0]          op_row;
  logic [IW-1:0]          op_col;
  logic [ADD_W-1:0]       op_add;

  mem_ctl_t               ctl;
  logic [IW-1:0]          mem_row;
  logic [IW-1:0]          mem_col;
  logic [VALUE_WIDTH-1:0] mem_rd;
  logic [VALUE_WIDTH-1:0] mem_wr;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  // A node is usable when it is within both the configured count and the store.
  assign np_x   = XW'(node_plus);
  assign nm_x   = XW'(node_minus);
  assign ok_p   = (node_plus <= node_count) && (np_x <= XW'(MAX_DIM));
  assign ok_m   = (node_minus <= node_count) && (nm_x <= XW'(MAX_DIM));
  assign r_full = XW'(node_count) + XW'(extra_used);
  assign row_x  = XW'(read_row);
  assign col_x  = XW'(read_column);

  // One step of the current stamp; ground steps and an inductor's RHS step are disabled.
  always_comb begin
    op_en  = 1'b0;
    op_vec = 1'b0;
    op_row = p;
    op_col = p;
    op_add = '0;
    unique case (kind)
      KIND_RES: begin
        unique case (step)
          3'd0: begin
            op_en = np_nz; op_row = p; op_col = p; op_add = {g[VALUE_WIDTH-1], g};
          end
          3'd1: begin
            op_en = np_nz && nm_nz; op_row = p; op_col = m;
            op_add = -{g[VALUE_WIDTH-1], g};
          end
          3'd2: begin
            op_en = np_nz && nm_nz; op_row = m; op_col = p;
            op_add = -{g[VALUE_WIDTH-1], g};
          end
          3'd3: begin
            op_en = nm_nz; op_row = m; op_col = m; op_add = {g[VALUE_WIDTH-1], g};
          end
          default: op_en = 1'b0;
        endcase
      end
      KIND_CUR: begin
        op_vec = 1'b1;
        unique case (step)
          3'd0: begin
            op_en = np_nz; op_row = p; op_add = -{val[VALUE_WIDTH-1], val};
          end
          3'd1: begin
            op_en = nm_nz; op_row = m; op_add = {val[VALUE_WIDTH-1], val};
          end
          default: op_en = 1'b0;
        endcase
      end
      KIND_VS, KIND_IND: begin
        unique case (step)
          3'd0: begin
            op_en = (kind == KIND_VS); op_vec = 1'b1; op_row = r;
            op_add = {val[VALUE_WIDTH-1], val};
          end
          3'd1: begin op_en = np_nz; op_row = r; op_col = p; op_add = ADD_ONE; end
          3'd2: begin op_en = np_nz; op_row = p; op_col = r; op_add = ADD_ONE; end
          3'd3: begin op_en = nm_nz; op_row = r; op_col = m; op_add = ADD_MINUS_ONE; end
          3'd4: begin op_en = nm_nz; op_row = m; op_col = r; op_add = ADD_MINUS_ONE; end
          default: op_en = 1'b0;
        endcase
      end
      default: op_en = 1'b0;
    endcase
  end

  // Memory port steering.
  always_comb begin
    ctl     = '0;
    mem_row = op_row;
    mem_col = op_col;
    mem_wr  = sat_add(mem_rd, op_add);
    unique case (state)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        mem_row = sweep[SW-1:IW];
        mem_col = sweep[IW-1:0];
      end
      ST_RD: begin
        ctl.rd  = 1'b1;
        ctl.vec = rd_vec;
        mem_row = rd_row;
        mem_col = rd_col;
      end
      ST_OP_RD: begin
        ctl.rd  = op_en;
        ctl.vec = op_vec;
      end
      ST_OP_WR: begin
        ctl.wr  = 1'b1;
        ctl.vec = op_vec;
      end
      default: ctl = '0;
    endcase
  end

  mna_mem #(.MAX_DIM(MAX_DIM)) u_mem (
    .clk     (clk),
    .ctl     (ctl),
    .row     (mem_row),
    .col     (mem_col),
    .wr_data (mem_wr),
    .rd_data (mem_rd)
  );

  mna_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (val),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      node_count   <= '0;
      extra_used   <= '0;
      sweep        <= '0;
      clear_post   <= 1'b0;
      div_start    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      // The output register loads a finished command once it is free.
      if (state == ST_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) begin
            state <= clear_post ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            kind        <= element_kind;
            val         <= element_value;
            np_nz       <= (node_plus != '0);
            nm_nz       <= (node_minus != '0);
            p           <= IW'(np_x - 1'b1);
            m           <= IW'(nm_x - 1'b1);
            r           <= r_full[IW-1:0];
            rd_row      <= row_x[IW-1:0];
            rd_col      <= col_x[IW-1:0];
            rd_vec      <= (command == CMD_RD_VEC);
            step        <= '0;
            pend_value  <= '0;
            pend_status <= STATUS_OK;
            unique case (command)
              CMD_STAMP: begin
                if (!ok_p || !ok_m) begin
                  pend_status <= STATUS_RANGE;
                  state       <= ST_DONE;
                end else if (element_kind == KIND_RES) begin
                  if (element_value == '0) begin
                    pend_status <= STATUS_ZERO_RES;
                    state       <= ST_DONE;
                  end else begin
                    div_start <= 1'b1;
                    state     <= ST_DIV;
                  end
                end else if (element_kind == KIND_CUR) begin
                  state <= ST_OP_RD;
                end else if (r_full >= XW'(MAX_DIM)) begin
                  pend_status <= STATUS_EXHAUSTED;
                  state       <= ST_DONE;
                end else begin
                  extra_used <= extra_used + 1'b1;
                  state      <= ST_OP_RD;
                end
              end
              CMD_RD_MAT: begin
                if (row_x >= XW'(MAX_DIM) || col_x >= XW'(MAX_DIM)) begin
                  pend_status <= STATUS_RANGE;
                  state       <= ST_DONE;
                end else begin
                  state <= ST_RD;
                end
              end
              CMD_RD_VEC: begin
                if (row_x >= XW'(MAX_DIM)) begin
                  pend_status <= STATUS_RANGE;
                  state       <= ST_DONE;
                end else begin
                  state <= ST_RD;
                end
              end
              CMD_CLEAR: begin
                extra_used <= '0;
                sweep      <= '0;
                clear_post <= 1'b1;
                state      <= ST_CLEAR;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            g     <= div_q;
            state <= ST_OP_RD;
          end
        end
        ST_OP_RD: begin
          if (op_en) begin
            state <= ST_OP_WR;
          end else if (step == 3'd4) begin
            state <= ST_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_OP_WR: begin
          if (step == 3'd4) begin
            state <= ST_DONE;
          end else begin
            step  <= step + 1'b1;
            state <= ST_OP_RD;
          end
        end
        ST_RD: begin
          state <= ST_RD_CAP;
        end
        ST_RD_CAP: begin
          pend_value <= mem_rd;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            read_value <= pend_value;
            status     <= pend_status;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_extra_bound, clk, rst, extra_used <= (IW + 1)'(MAX_DIM))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, item_stall)
  `ASSERT_IMPLY(a_div_done_in_div, clk, rst, div_done, state == ST_DIV)

endmodule
`default_nettype wire

>>> hw/rtl/mna_recip.sv
// Bit-serial reciprocal unit: computes 2^32 / divisor, truncated and saturated.
`timescale 1ns / 1ps
`default_nettype none
module mna_recip import mna_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic                   busy;
  logic                   fin;
  logic                   first;
  logic                   neg;
  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH-1:0] dmag;
  logic [VALUE_WIDTH-1:0] rem;
  logic [DIV_W-1:0]       q;

  logic [VALUE_WIDTH:0]   sh;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;
  logic [VALUE_WIDTH-1:0] rem_next;
  logic [VALUE_WIDTH-1:0] clamped;

  // The dividend is a single one followed by zeros, so only the first step shifts in a one.
  assign sh       = {rem, first};
  assign ge       = sh >= {1'b0, dmag};
  assign diff     = sh - {1'b0, dmag};
  assign rem_next = ge ? diff[VALUE_WIDTH-1:0] : sh[VALUE_WIDTH-1:0];

  always_comb begin
    if (!neg) begin
      clamped = (q > DIV_W'(VMAX)) ? VMAX : q[VALUE_WIDTH-1:0];
    end else begin
      clamped = (q > DIV_W'(VMIN)) ? VMIN : -q[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        fin   <= 1'b0;
        first <= 1'b1;
        cnt   <= CW'(DIV_W - 1);
        rem   <= '0;
        q     <= '0;
        neg   <= divisor[VALUE_WIDTH-1];
        dmag  <= divisor[VALUE_WIDTH-1] ? -divisor : divisor;
      end else if (busy) begin
        rem   <= rem_next;
        q     <= {q[DIV_W-2:0], ge};
        first <= 1'b0;
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end else if (fin) begin
        fin      <= 1'b0;
        done     <= 1'b1;
        quotient <= clamped;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/mna_mem.sv
// Matrix and right-hand-side memories with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mna_mem import mna_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                           clk,
  input  mem_ctl_t                       ctl,
  input  logic [$clog2(MAX_DIM)-1:0]     row,
  input  logic [$clog2(MAX_DIM)-1:0]     col,
  input  logic [VALUE_WIDTH-1:0]         wr_data,
  output logic [VALUE_WIDTH-1:0]         rd_data
);

  localparam int IW = $clog2(MAX_DIM);

  logic [VALUE_WIDTH-1:0] mat [(1 << (2 * IW))];
  logic [VALUE_WIDTH-1:0] vec [(1 << IW)];
  logic [VALUE_WIDTH-1:0] mat_q;
  logic [VALUE_WIDTH-1:0] vec_q;
  logic                   sel_vec;

  always_ff @(posedge clk) begin
    if (ctl.clr || (ctl.wr && !ctl.vec)) begin
      mat[{row, col}] <= ctl.clr ? '0 : wr_data;
    end
    // The clearing sweep zeroes one vector entry per matrix row.
    if ((ctl.clr && col == '0) || (ctl.wr && ctl.vec)) begin
      vec[row] <= ctl.clr ? '0 : wr_data;
    end
    if (ctl.rd) begin
      mat_q   <= mat[{row, col}];
      vec_q   <= vec[row];
      sel_vec <= ctl.vec;
    end
  end

  assign rd_data = sel_vec ? vec_q : mat_q;

endmodule
`default_nettype wire

>>> bench/tb_mna_matrix_stamper.sv
// Self-checking testbench for the MNA matrix stamper: random and directed commands.
`timescale 1ns / 1ps
`default_nettype none
module tb_mna_matrix_stamper;
  import mna_pkg::*;

  localparam int DIM = 128;
  localparam int WATCHDOG_LIMIT = 200000;

  // One command transaction as it is driven onto the item channel.
  typedef struct {
    logic [1:0]  command;
    logic [1:0]  element_kind;
    logic [7:0]  node_plus;
    logic [7:0]  node_minus;
    logic [31:0] element_value;
    logic [6:0]  read_row;
    logic [6:0]  read_column;
  } stamp_cmd_t;

  typedef struct {
    logic [31:0] read_value;
    logic [1:0]  status;
  } stamp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] command = '0;
  logic [1:0] element_kind = '0;
  logic [7:0] node_plus = '0;
  logic [7:0] node_minus = '0;
  logic [31:0] element_value = '0;
  logic [6:0] read_row = '0;
  logic [6:0] read_column = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [31:0] read_value;
  logic [1:0] status;

  always #6 clk = ~clk;

  mna_matrix_stamper dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .element_kind(element_kind),
    .node_plus(node_plus), .node_minus(node_minus),
    .element_value(element_value), .read_row(read_row), .read_column(read_column),
    .result_valid(result_valid), .result_stall(result_stall),
    .read_value(read_value), .status(status)
  );

  // Shadow copy of the block's state, kept as wide signed values.
  longint shadow_matrix [DIM][DIM];
  longint shadow_rhs [DIM];
  int unsigned shadow_extra_rows;
  int unsigned shadow_node_count;

  stamp_cmd_t pending_cmds[$];
  stamp_result_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  bit hold_off_req = 1'b0;
  bit hold_off_taken = 1'b0;
  int unsigned hold_off_left = 0;
  bit item_accept, result_accept;

  function automatic longint clamp_q16(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  // Inputs fit 33-bit signed; sums stay well within 64 bits, so clamp after add.
  function automatic longint q16_sat_add(longint a, longint b);
    return clamp_q16(a + b);
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_matrix[r, c]) shadow_matrix[r][c] = 0;
    foreach (shadow_rhs[r]) shadow_rhs[r] = 0;
    shadow_extra_rows = 0;
  endfunction

  function automatic bit node_valid(int unsigned n);
    return n <= shadow_node_count && n <= DIM;
  endfunction

  // Applies one element's stamp to the shadow state and returns the status.
  function automatic logic [1:0] apply_stamp(stamp_cmd_t c);
    int unsigned np, nm, p, m, r;
    longint val, g;
    np = 32'(c.node_plus);
    nm = 32'(c.node_minus);
    val = longint'($signed(c.element_value));
    if (!node_valid(np) || !node_valid(nm)) return STATUS_RANGE;
    p = np - 1;
    m = nm - 1;
    case (c.element_kind)
      KIND_RES: begin
        if (val == 0) return STATUS_ZERO_RES;
        // SystemVerilog division truncates toward zero, as required.
        g = clamp_q16((64'sd1 <<< 32) / val);
        if (np != 0) shadow_matrix[p][p] = q16_sat_add(shadow_matrix[p][p], g);
        if (np != 0 && nm != 0) begin
          shadow_matrix[p][m] = q16_sat_add(shadow_matrix[p][m], -g);
          shadow_matrix[m][p] = q16_sat_add(shadow_matrix[m][p], -g);
        end
        if (nm != 0) shadow_matrix[m][m] = q16_sat_add(shadow_matrix[m][m], g);
        return STATUS_OK;
      end
      KIND_CUR: begin
        if (np != 0) shadow_rhs[p] = q16_sat_add(shadow_rhs[p], -val);
        if (nm != 0) shadow_rhs[m] = q16_sat_add(shadow_rhs[m], val);
        return STATUS_OK;
      end
      default: begin
        // Voltage sources and inductors claim the next branch-current row.
        r = shadow_node_count + shadow_extra_rows;
        if (r >= DIM) return STATUS_EXHAUSTED;
        shadow_extra_rows++;
        if (c.element_kind == KIND_VS) shadow_rhs[r] = q16_sat_add(shadow_rhs[r], val);
        if (np != 0) begin
          shadow_matrix[r][p] = q16_sat_add(shadow_matrix[r][p], 65536);
          shadow_matrix[p][r] = q16_sat_add(shadow_matrix[p][r], 65536);
        end
        if (nm != 0) begin
          shadow_matrix[r][m] = q16_sat_add(shadow_matrix[r][m], -65536);
          shadow_matrix[m][r] = q16_sat_add(shadow_matrix[m][r], -65536);
        end
        return STATUS_OK;
      end
    endcase
  endfunction

  // Works out the one result a command transaction produces.
  function automatic stamp_result_t predict_result(stamp_cmd_t c);
    stamp_result_t res;
    res.read_value = '0;
    res.status = STATUS_OK;
    case (c.command)
      CMD_STAMP: res.status = apply_stamp(c);
      CMD_RD_MAT: res.read_value = shadow_matrix[c.read_row][c.read_column][31:0];
      CMD_RD_VEC: res.read_value = shadow_rhs[c.read_row][31:0];
      default: clear_shadow();
    endcase
    return res;
  endfunction

  // Driver: presents queued commands, holding the payload while stalled.
  always @(negedge clk) begin
    if (!rst) begin
      if (!item_valid || item_accept) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          stamp_cmd_t c;
          c = pending_cmds.pop_front();
          command <= c.command;
          element_kind <= c.element_kind;
          node_plus <= c.node_plus;
          node_minus <= c.node_minus;
          element_value <= c.element_value;
          read_row <= c.read_row;
          read_column <= c.read_column;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here once requested.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken <= 1'b1;
        hold_off_left <= 400;
        result_stall <= 1'b1;
      end else if (hold_off_left > 0) begin
        result_stall <= 1'b1;
        hold_off_left <= hold_off_left - 1;
      end else begin
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // Monitor: predicts on each accepted command and checks each accepted result.
  always @(posedge clk) begin
    item_accept = item_valid && !item_stall;
    result_accept = result_valid && !result_stall;
    if (!rst) begin
      if (item_accept) begin
        stamp_cmd_t c;
        c.command = command;
        c.element_kind = element_kind;
        c.node_plus = node_plus;
        c.node_minus = node_minus;
        c.element_value = element_value;
        c.read_row = read_row;
        c.read_column = read_column;
        expected_results.push_back(predict_result(c));
      end
      if (result_accept) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_value %h status %0d", read_value, status);
          error_count++;
        end else begin
          stamp_result_t e;
          e = expected_results.pop_front();
          if (read_value !== e.read_value) begin
            $error("read_value expected %h actual %h", e.read_value, read_value);
            error_count++;
          end
          if (status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: the clearing sweep after reset and clear counts as quiet time.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_valid)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic stamp_cmd_t make_cmd(logic [1:0] cmd, logic [1:0] kind, int np, int nm,
                                          logic [31:0] val, int row, int col);
    stamp_cmd_t c;
    c.command = cmd;
    c.element_kind = kind;
    c.node_plus = np[7:0];
    c.node_minus = nm[7:0];
    c.element_value = val;
    c.read_row = row[6:0];
    c.read_column = col[6:0];
    return c;
  endfunction

  // A node mostly within the configured range, now and then beyond it.
  function automatic int pick_node(int unsigned nodes);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) return $urandom_range(255);
    if (sel < 20) return 0;
    return $urandom_range(nodes);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(3);
      3: return $urandom();
      default: return $urandom_range(32'h000fffff, 32'h00001000) ^
                      ($urandom_range(1) ? 32'hffffffff : 32'h0);
    endcase
  endfunction

  // A random mix of stamps, reads over the rows they may touch, and rare clears.
  task automatic queue_random(int unsigned count, int unsigned nodes);
    int unsigned lim;
    lim = nodes + 12;
    repeat (count) begin
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 45)
        pending_cmds.push_back(make_cmd(CMD_STAMP, 2'($urandom_range(3)), pick_node(nodes),
                               pick_node(nodes), pick_value(), 0, 0));
      else if (sel < 75)
        pending_cmds.push_back(make_cmd(CMD_RD_MAT, 2'($urandom_range(3)),
                               $urandom_range(255), $urandom_range(255), $urandom(),
                               $urandom_range(lim > 127 ? 127 : lim),
                               $urandom_range(99) < 5 ? $urandom_range(127) :
                               $urandom_range(lim > 127 ? 127 : lim)));
      else if (sel < 97)
        pending_cmds.push_back(make_cmd(CMD_RD_VEC, 2'($urandom_range(3)),
                               $urandom_range(255), $urandom_range(255), $urandom(),
                               $urandom_range(99) < 5 ? $urandom_range(127) :
                               $urandom_range(lim > 127 ? 127 : lim), $urandom_range(127)));
      else
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 2'($urandom_range(3)),
                               $urandom_range(255), $urandom_range(255), $urandom(),
                               $urandom_range(127), $urandom_range(127)));
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    // A clear answers only after its sweep; a handshake waits a sweep out anyway.
    repeat (60) @(posedge clk);
  endtask

  task automatic write_node_count(logic [7:0] n);
    @(negedge clk);
    cfg_data <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    shadow_node_count = 32'(n);
  endtask

  initial begin
    clear_shadow();
    shadow_node_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with no nodes: every node but ground is out of range.
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 1, 0, 32'h00010000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_VS, 0, 0, 32'h00020000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RD_VEC, KIND_RES, 0, 0, 0, 0, 0));
    drain();

    write_node_count(8'd4);
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 1, 2, 32'h00010000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 1, 0, 32'h00000000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 2, 0, 32'h00000001, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 3, 4, 32'hffff0000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 3, 3, 32'h7fffffff, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 2, 0, 32'h80000000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_CUR, 1, 4, 32'h80000000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_CUR, 1, 4, 32'h80000000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_VS, 1, 0, 32'h7fffffff, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_IND, 2, 3, 32'h12345678, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_CUR, 5, 1, 32'h00010000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 255, 1, 32'h00010000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RD_MAT, KIND_IND, 255, 255, 32'hffffffff, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RD_MAT, KIND_RES, 0, 0, 0, 1, 1));
    pending_cmds.push_back(make_cmd(CMD_RD_MAT, KIND_RES, 0, 0, 0, 4, 0));
    pending_cmds.push_back(make_cmd(CMD_RD_MAT, KIND_RES, 0, 0, 0, 2, 2));
    pending_cmds.push_back(make_cmd(CMD_RD_VEC, KIND_RES, 0, 0, 0, 0, 127));
    pending_cmds.push_back(make_cmd(CMD_RD_VEC, KIND_RES, 0, 0, 0, 4, 0));
    pending_cmds.push_back(make_cmd(CMD_RD_MAT, KIND_RES, 0, 0, 0, 127, 127));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, KIND_IND, 255, 255, 32'hffffffff, 127, 127));
    pending_cmds.push_back(make_cmd(CMD_RD_MAT, KIND_RES, 0, 0, 0, 0, 0));
    drain();

    // Full node range: extra rows are exhausted at once; all 8 node bits are used.
    write_node_count(8'd128);
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_VS, 128, 127, 32'h00010000, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_STAMP, KIND_RES, 128, 127, 32'h00000003, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RD_MAT, KIND_RES, 0, 0, 0, 127, 126));
    pending_cmds.push_back(make_cmd(CMD_RD_MAT, KIND_RES, 0, 0, 0, 127, 127));
    queue_random(120, 128);
    drain();

    // Random phases: no idling, idle sender, stalling receiver, both.
    write_node_count(8'd6);
    queue_random(180, 6);
    drain();

    write_node_count(8'd120);
    sender_idle_pct = 60;
    queue_random(150, 120);
    drain();

    write_node_count(8'd3);
    sender_idle_pct = 0;
    receiver_stall_pct = 60;
    // Long receiver hold-off while commands keep coming, so the input backs up.
    hold_off_req = 1'b1;
    queue_random(180, 3);
    drain();

    write_node_count(8'd0);
    sender_idle_pct = 26;
    receiver_stall_pct = 26;
    queue_random(40, 2);
    drain();

    write_node_count(8'd10);
    queue_random(160, 10);
    drain();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mna_pkg.sv
hw/rtl/mna_recip.sv
hw/rtl/mna_mem.sv
hw/rtl/mna_matrix_stamper.sv
bench/tb_mna_matrix_stamper.sv
